// ===== sv/ogt_pkg.sv =====
// ----------------------------------------------------------------------------
// ogt_pkg
// Shared widths, constants and the CORDIC angle table for the ground track unit.
// ----------------------------------------------------------------------------
package ogt_pkg;

	localparam int CW = 40;
	localparam int ZW = 34;

	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	localparam logic [2:0] REG_ORBIT_RATE    = 3'd0;
	localparam logic [2:0] REG_START_PHASE   = 3'd1;
	localparam logic [2:0] REG_ASCENDING_LON = 3'd2;
	localparam logic [2:0] REG_SIN_INCL      = 3'd3;
	localparam logic [2:0] REG_COS_INCL      = 3'd4;
	localparam logic [2:0] REG_EARTH_RATE    = 3'd5;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [ZW-1:0] zval_t;

	function automatic logic [31:0] atan_step(input int i);
		logic [31:0] a;
		case (i)
			0: a = 32'h20000000;
			1: a = 32'h12E4051E;
			2: a = 32'h09FB385B;
			3: a = 32'h051111D4;
			4: a = 32'h028B0D43;
			5: a = 32'h0145D7E1;
			6: a = 32'h00A2F61E;
			7: a = 32'h00517C55;
			8: a = 32'h0028BE53;
			9: a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

// ===== sv/ogt_phase.sv =====
// ----------------------------------------------------------------------------
// ogt_phase
// Two-stage wrapped rate-times-time product, giving orbit phase and Earth spin.
// ----------------------------------------------------------------------------
module ogt_phase (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_in,
	input  logic [47:0] time_ticks,
	input  logic [47:0] orbit_rate,
	input  logic [47:0] earth_rate,
	input  logic [31:0] start_phase,
	output logic        v_out,
	output logic [31:0] phase,
	output logic [31:0] spin
);
	import ogt_pkg::*;

	logic        v_s1, v_s2;
	logic [63:0] opa_s1, epa_s1;
	logic [31:0] opb_s1, opc_s1, epb_s1, epc_s1;
	logic [31:0] phase_s2, spin_s2;
	logic [47:0] opb_w, opc_w, epb_w, epc_w;

	assign opb_w = orbit_rate[31:0] * time_ticks[47:32];
	assign opc_w = time_ticks[31:0] * orbit_rate[47:32];
	assign epb_w = earth_rate[31:0] * time_ticks[47:32];
	assign epc_w = time_ticks[31:0] * earth_rate[47:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			opa_s1   <= orbit_rate[31:0] * time_ticks[31:0];
			epa_s1   <= earth_rate[31:0] * time_ticks[31:0];
			opb_s1   <= opb_w[31:0];
			opc_s1   <= opc_w[31:0];
			epb_s1   <= epb_w[31:0];
			epc_s1   <= epc_w[31:0];
			phase_s2 <= start_phase + opa_s1[63:32] + opb_s1 + opc_s1;
			spin_s2  <= epa_s1[63:32] + epb_s1 + epc_s1;
		end
	end

	assign v_out = v_s2;
	assign phase = phase_s2;
	assign spin  = spin_s2;

endmodule

// ===== sv/ogt_rot.sv =====
// ----------------------------------------------------------------------------
// ogt_rot
// One CORDIC rotation-mode iteration as a pipeline stage.
// ----------------------------------------------------------------------------
module ogt_rot #(
	parameter int STEP = 0,
	parameter int SW   = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  ogt_pkg::cval_t x_in,
	input  ogt_pkg::cval_t y_in,
	input  ogt_pkg::zval_t z_in,
	input  logic [SW-1:0] side_in,
	output logic          v_out,
	output ogt_pkg::cval_t x_out,
	output ogt_pkg::cval_t y_out,
	output ogt_pkg::zval_t z_out,
	output logic [SW-1:0] side_out
);
	import ogt_pkg::*;

	logic          v_s1;
	cval_t         x_s1, y_s1;
	zval_t         z_s1;
	logic [SW-1:0] side_s1;
	zval_t         a;

	assign a = zval_t'({{(ZW-32){1'b0}}, atan_step(STEP)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			if (z_in >= 0) begin
				x_s1 <= x_in - (y_in >>> STEP);
				y_s1 <= y_in + (x_in >>> STEP);
				z_s1 <= z_in - a;
			end else begin
				x_s1 <= x_in + (y_in >>> STEP);
				y_s1 <= y_in - (x_in >>> STEP);
				z_s1 <= z_in + a;
			end
		end
	end

	assign v_out    = v_s1;
	assign x_out    = x_s1;
	assign y_out    = y_s1;
	assign z_out    = z_s1;
	assign side_out = side_s1;

endmodule

// ===== sv/ogt_vec.sv =====
// ----------------------------------------------------------------------------
// ogt_vec
// One CORDIC vectoring-mode iteration as a pipeline stage.
// ----------------------------------------------------------------------------
module ogt_vec #(
	parameter int STEP = 0,
	parameter int SW   = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  ogt_pkg::cval_t x_in,
	input  ogt_pkg::cval_t y_in,
	input  logic [31:0]   z_in,
	input  logic [SW-1:0] side_in,
	output logic          v_out,
	output ogt_pkg::cval_t x_out,
	output ogt_pkg::cval_t y_out,
	output logic [31:0]   z_out,
	output logic [SW-1:0] side_out
);
	import ogt_pkg::*;

	logic          v_s1;
	cval_t         x_s1, y_s1;
	logic [31:0]   z_s1;
	logic [SW-1:0] side_s1;
	logic [31:0]   a;

	assign a = atan_step(STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			if (y_in >= 0) begin
				x_s1 <= x_in + (y_in >>> STEP);
				y_s1 <= y_in - (x_in >>> STEP);
				z_s1 <= z_in + a;
			end else begin
				x_s1 <= x_in - (y_in >>> STEP);
				y_s1 <= y_in + (x_in >>> STEP);
				z_s1 <= z_in - a;
			end
		end
	end

	assign v_out    = v_s1;
	assign x_out    = x_s1;
	assign y_out    = y_s1;
	assign z_out    = z_s1;
	assign side_out = side_s1;

endmodule

// ===== sv/orbit_ground_track_unit.sv =====
// ----------------------------------------------------------------------------
// orbit_ground_track_unit
// Sub-satellite point of a circular orbit from a time stamp.
//
// Input channel (in_valid/in_ready, time_ticks) takes one time stamp per item;
// output channel (out_valid/out_ready, latitude, longitude) returns one result
// item per input item, in order. Configuration writes arrive on cfg_valid,
// cfg_index, cfg_data; cfg_ready is always high and writes take effect in the next cycle.
// Write configuration only while no item is in flight.
// The pipeline is the rate-times-time product stages, one rotation CORDIC, one
// multiply stage, two vectoring CORDICs each one step per stage, one gain stage
// and the output buffer. Throughput is one item per cycle while the output
// buffer is not full.
// A two-entry output buffer holds results while out_ready is low; the whole
// pipeline holds when it is full and in_ready drops until an item is taken.
// Reset clears all valid bits and loads the configuration reset values.
// ----------------------------------------------------------------------------
module orbit_ground_track_unit #(
	parameter int CORDIC_STEPS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [47:0] time_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] latitude,
	output logic [31:0] longitude,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);
	import ogt_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic [47:0]        orbit_rate_q, earth_rate_q;
	logic [31:0]        start_phase_q, ascending_lon_q;
	logic [30:0]        sin_incl_q;
	logic signed [31:0] cos_incl_q;

	logic en;

	// configuration
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orbit_rate_q    <= '0;
			start_phase_q   <= '0;
			ascending_lon_q <= '0;
			sin_incl_q      <= '0;
			cos_incl_q      <= ONE_Q30;
			earth_rate_q    <= 48'd3257812230;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ORBIT_RATE:    orbit_rate_q    <= cfg_data;
				REG_START_PHASE:   start_phase_q   <= cfg_data[31:0];
				REG_ASCENDING_LON: ascending_lon_q <= cfg_data[31:0];
				REG_SIN_INCL:      sin_incl_q      <= cfg_data[30:0];
				REG_COS_INCL:      cos_incl_q      <= cfg_data[31:0];
				REG_EARTH_RATE:    earth_rate_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// phase products
	logic        v_ph;
	logic [31:0] phase, spin;

	ogt_phase u_phase (
		.clk, .arst_n, .en,
		.v_in        (in_valid & in_ready),
		.time_ticks,
		.orbit_rate  (orbit_rate_q),
		.earth_rate  (earth_rate_q),
		.start_phase (start_phase_q),
		.v_out       (v_ph),
		.phase,
		.spin
	);

	// rotation CORDIC: cos and sin of phase
	logic        flip;
	logic [31:0] ang;
	logic        rv [0:N];
	cval_t       rx [0:N];
	cval_t       ry [0:N];
	zval_t       rz [0:N];
	logic [32:0] rs [0:N];

	assign flip  = phase[31] ^ phase[30];
	assign ang   = phase ^ {flip, 31'd0};
	assign rv[0] = v_ph;
	assign rx[0] = cval_t'({{(CW-30){1'b0}}, INV_GAIN_Q30});
	assign ry[0] = '0;
	assign rz[0] = zval_t'({{(ZW-32){ang[31]}}, ang});
	assign rs[0] = {flip, spin};

	for (genvar k = 0; k < N; k++) begin : g_rot
		ogt_rot #(.STEP(k), .SW(33)) u_rot (
			.clk, .arst_n, .en,
			.v_in (rv[k]), .x_in (rx[k]), .y_in (ry[k]), .z_in (rz[k]), .side_in (rs[k]),
			.v_out (rv[k+1]), .x_out (rx[k+1]), .y_out (ry[k+1]), .z_out (rz[k+1]),
			.side_out (rs[k+1])
		);
	end

	// incline multiplies
	cval_t                c_w, s_w;
	logic signed [33:0]   s_n;
	logic signed [CW+29:0] py_w, pz_w;
	logic                 v_s3;
	cval_t                c_s3, vy_s3, vz_s3;
	logic [31:0]          spin_s3;

	assign c_w  = rs[N][32] ? -rx[N] : rx[N];
	assign s_w  = rs[N][32] ? -ry[N] : ry[N];
	assign s_n  = s_w[33:0];
	assign py_w = s_n * cos_incl_q;
	assign pz_w = s_n * $signed({1'b0, sin_incl_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= rv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3    <= c_w;
			vy_s3   <= py_w[CW+29:30];
			vz_s3   <= pz_w[CW+29:30];
			spin_s3 <= rs[N][31:0];
		end
	end

	// vectoring CORDIC: orbit-plane longitude
	logic        av [0:N];
	cval_t       ax [0:N];
	cval_t       ay [0:N];
	logic [31:0] az [0:N];
	logic [71:0] as [0:N];

	assign av[0] = v_s3;
	assign ax[0] = c_s3[CW-1] ? -c_s3 : c_s3;
	assign ay[0] = c_s3[CW-1] ? -vy_s3 : vy_s3;
	assign az[0] = c_s3[CW-1] ? HALF_TURN : 32'd0;
	assign as[0] = {spin_s3, vz_s3};

	for (genvar k = 0; k < N; k++) begin : g_vec_a
		ogt_vec #(.STEP(k), .SW(72)) u_vec (
			.clk, .arst_n, .en,
			.v_in (av[k]), .x_in (ax[k]), .y_in (ay[k]), .z_in (az[k]), .side_in (as[k]),
			.v_out (av[k+1]), .x_out (ax[k+1]), .y_out (ay[k+1]), .z_out (az[k+1]),
			.side_out (as[k+1])
		);
	end

	// gain correction
	logic signed [CW+29:0] pr_w;
	logic               v_s4;
	cval_t              r_s4, vz_s4;
	logic [31:0]        orb_s4, spin_s4;

	assign pr_w = ax[N][34:0] * $signed({1'b0, INV_GAIN_Q30});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= av[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s4    <= pr_w[CW+29:30];
			vz_s4   <= as[N][CW-1:0];
			orb_s4  <= az[N];
			spin_s4 <= as[N][71:40];
		end
	end

	// vectoring CORDIC: latitude
	logic        bv [0:N];
	cval_t       bx [0:N];
	cval_t       by [0:N];
	logic [31:0] bz [0:N];
	logic [63:0] bs [0:N];

	assign bv[0] = v_s4;
	assign bx[0] = r_s4[CW-1] ? -r_s4 : r_s4;
	assign by[0] = r_s4[CW-1] ? -vz_s4 : vz_s4;
	assign bz[0] = r_s4[CW-1] ? HALF_TURN : 32'd0;
	assign bs[0] = {spin_s4, orb_s4};

	for (genvar k = 0; k < N; k++) begin : g_vec_b
		ogt_vec #(.STEP(k), .SW(64)) u_vec (
			.clk, .arst_n, .en,
			.v_in (bv[k]), .x_in (bx[k]), .y_in (by[k]), .z_in (bz[k]), .side_in (bs[k]),
			.v_out (bv[k+1]), .x_out (bx[k+1]), .y_out (by[k+1]), .z_out (bz[k+1]),
			.side_out (bs[k+1])
		);
	end

	// clamp, longitude and output buffer
	logic signed [31:0] lat_w;
	logic [31:0]        lon_w;
	logic [63:0]        res_w;
	logic [63:0]        ent0_q, ent1_q;
	logic [1:0]         cnt_q;
	logic               push, pop;

	always_comb begin
		lat_w = bz[N];
		if (lat_w > $signed(ONE_Q30)) begin
			lat_w = ONE_Q30;
		end else if (lat_w < -$signed(ONE_Q30)) begin
			lat_w = -$signed(ONE_Q30);
		end
	end

	assign lon_w = bs[N][31:0] - bs[N][63:32] + ascending_lon_q;
	assign res_w = {lat_w, lon_w};

	assign en        = (cnt_q != 2'd2);
	assign in_ready  = en;
	assign push      = en & bv[N];
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid & out_ready;
	assign latitude  = ent0_q[63:32];
	assign longitude = ent0_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					ent0_q <= res_w;
				end else begin
					ent1_q <= res_w;
				end
			end
			2'b01: ent0_q <= ent1_q;
			2'b11: ent0_q <= res_w;
			default: ;
		endcase
	end

endmodule

// ===== sv/ogt_check.sv =====
// ----------------------------------------------------------------------------
// ogt_check
// Port-level checks for the ground track unit, bound to the top level.
// ----------------------------------------------------------------------------
module ogt_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] latitude,
	input logic [31:0] longitude,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(latitude) && $stable(longitude))
		else $error("result item changed while stalled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input held off with no result waiting");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(latitude) <= 32'sh4000_0000 &&
			$signed(latitude) >= -32'sh4000_0000))
		else $error("latitude beyond a quarter turn");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind orbit_ground_track_unit ogt_check u_ogt_check (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.latitude, .longitude, .cfg_valid, .cfg_ready
);
